// ===== rtl/uere_pkg.sv =====
// ----------------------------------------------------------------------------
// uere_pkg
// Shared types, register indexes and constants of the echo ranger with
// moving average.
// ----------------------------------------------------------------------------
package uere_pkg;

	localparam int FRAC_BITS   = 8;
	localparam int COUNT_BITS  = 17;
	localparam int QUEUE_DEPTH = 2;

	localparam int Q_BITS      = 19;
	localparam int SCALE_BITS  = 16;
	localparam int TIMEOUT_W   = 16;
	localparam int ALPHA_W     = 9;
	localparam int ALPHA_BITS  = 8;
	localparam int PERIOD_BITS = 17;
	localparam int TRIG_W      = 8;
	localparam int CFG_DATA_W  = 19;
	localparam int CFG_INDEX_W = 3;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
	localparam logic [Q_BITS-1:0]  Q_MAX     = 19'h7FFFF;

	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SCALE     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PERIOD    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TRIG_W    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_EMA_START = 3'd5;

	localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST = 16'd26100;
	localparam logic [ALPHA_W-1:0]     ALPHA_RST   = 9'd51;
	localparam logic [SCALE_BITS-1:0]  SCALE_RST   = 16'd1124;
	localparam logic [PERIOD_BITS-1:0] PERIOD_RST  = 17'd100000;
	localparam logic [TRIG_W-1:0]      TRIG_W_RST  = 8'd10;
	localparam logic [Q_BITS-1:0]      EMA_RST     = 19'd114589;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_TOUT = 2'd1;
	localparam logic [1:0] KIND_MEAS = 2'd2;

	typedef struct packed {
		logic [TIMEOUT_W-1:0]   timeout;
		logic [ALPHA_W-1:0]     alpha;
		logic [SCALE_BITS-1:0]  scale;
		logic [PERIOD_BITS-1:0] period;
		logic [TRIG_W-1:0]      trig_width;
	} cfg_t;

	typedef struct packed {
		logic       trig;
		logic [1:0] kind;
	} op_t;

endpackage

// ===== rtl/uere_queue.sv =====
// ----------------------------------------------------------------------------
// uere_queue
// Small register FIFO between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module uere_queue #(
	parameter int WIDTH = 20,
	parameter int DEPTH = uere_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue push while full");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/uere_front.sv =====
// ----------------------------------------------------------------------------
// uere_front
// Takes echo words, runs the trigger period counter and the echo width
// counter, and classifies each tick as plain, timed out or measured.
// ----------------------------------------------------------------------------
module uere_front #(
	parameter int COUNT_BITS = uere_pkg::COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  uere_pkg::cfg_t        cfg,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  echo_level,
	input  logic                  q_full,
	output logic                  push,
	output uere_pkg::op_t         push_op,
	output logic [COUNT_BITS-1:0] push_width
);

	localparam logic [COUNT_BITS-1:0] WIDTH_MAX = '1;

	logic                             prev_echo_q, measuring_q;
	logic [COUNT_BITS-1:0]            width_q;
	logic [uere_pkg::PERIOD_BITS-1:0] period_q;
	logic [uere_pkg::PERIOD_BITS:0]   period_nxt;
	logic                             fall;

	assign in_stall   = q_full;
	assign push       = in_valid && !q_full;
	assign period_nxt = {1'b0, period_q} + 1'b1;
	assign fall       = !echo_level && prev_echo_q && measuring_q;

	always_comb begin
		push_op.trig = ({1'b0, period_q} < {{(uere_pkg::PERIOD_BITS + 1 - uere_pkg::TRIG_W){1'b0}},
			cfg.trig_width});
		if (!fall) begin
			push_op.kind = uere_pkg::KIND_NONE;
		end else if (width_q > COUNT_BITS'(cfg.timeout)) begin
			push_op.kind = uere_pkg::KIND_TOUT;
		end else begin
			push_op.kind = uere_pkg::KIND_MEAS;
		end
		push_width = width_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_echo_q <= 1'b0;
			measuring_q <= 1'b0;
			width_q     <= '0;
			period_q    <= '0;
		end else if (push) begin
			period_q <= (period_nxt >= {1'b0, cfg.period}) ? '0
				: period_nxt[uere_pkg::PERIOD_BITS-1:0];
			if (echo_level && !prev_echo_q) begin
				measuring_q <= 1'b1;
				width_q     <= COUNT_BITS'(1);
			end else if (echo_level && measuring_q) begin
				if (width_q != WIDTH_MAX) begin
					width_q <= width_q + 1'b1;
				end
			end else if (fall) begin
				measuring_q <= 1'b0;
			end
			prev_echo_q <= echo_level;
		end
	end

endmodule

// ===== rtl/uere_back.sv =====
// ----------------------------------------------------------------------------
// uere_back
// Converts a measured width to distance, updates the moving average and
// holds the result word until the receiver takes it.
// ----------------------------------------------------------------------------
module uere_back #(
	parameter int COUNT_BITS = uere_pkg::COUNT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  uere_pkg::cfg_t              cfg,
	input  logic                        ema_load,
	input  logic [uere_pkg::Q_BITS-1:0] ema_value,
	input  logic                        q_empty,
	input  uere_pkg::op_t               q_op,
	input  logic [COUNT_BITS-1:0]       q_width,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        trigger_level,
	output logic                        measure_done,
	output logic                        timed_out,
	output logic [uere_pkg::Q_BITS-1:0] distance_q8,
	output logic [uere_pkg::Q_BITS-1:0] smoothed_q8
);

	localparam int QB  = uere_pkg::Q_BITS;
	localparam int PW  = COUNT_BITS + uere_pkg::SCALE_BITS;
	localparam int SH  = uere_pkg::SCALE_BITS - uere_pkg::FRAC_BITS;
	localparam int DW  = QB + 1;
	localparam int MW  = DW + uere_pkg::ALPHA_W + 1;
	localparam int SW  = MW + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIF  = 3'd2;
	localparam logic [2:0] ST_MAC  = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;

	logic [2:0]                   st_q;
	logic [COUNT_BITS-1:0]        width_q;
	logic                         trig_hold_q;
	logic [PW-1:0]                prod_s1;
	logic [QB-1:0]                d_s2;
	logic signed [MW-1:0]         prod_s3;
	logic [QB-1:0]                avg_q, dist_q;
	logic                         out_valid_q, trig_q, done_q, tout_q;

	logic                         out_free, load_plain, load_meas;
	logic [PW-1:0]                shifted;
	logic [QB-1:0]                d_sat;
	logic [uere_pkg::ALPHA_W-1:0] alpha_eff;
	logic signed [DW-1:0]         diff;
	logic signed [MW-1:0]         step;
	logic signed [SW-1:0]         sum;
	logic [QB-1:0]                avg_new;

	assign out_free   = !out_valid_q || !out_stall;
	assign pop        = (st_q == ST_IDLE) && !q_empty
		&& ((q_op.kind == uere_pkg::KIND_MEAS) || out_free);
	assign load_plain = pop && (q_op.kind != uere_pkg::KIND_MEAS);
	assign load_meas  = (st_q == ST_UPD) && out_free;

	assign shifted   = prod_s1 >> SH;
	assign d_sat     = (|shifted[PW-1:QB]) ? uere_pkg::Q_MAX : shifted[QB-1:0];
	assign alpha_eff = (cfg.alpha > uere_pkg::ALPHA_ONE) ? uere_pkg::ALPHA_ONE : cfg.alpha;
	assign diff      = $signed({1'b0, d_s2}) - $signed({1'b0, avg_q});
	assign step      = prod_s3 >>> uere_pkg::ALPHA_BITS;
	assign sum       = $signed({{(SW - QB){1'b0}}, avg_q}) + $signed({step[MW-1], step});

	always_comb begin
		if (sum[SW-1]) begin
			avg_new = '0;
		end else if (|sum[SW-2:QB]) begin
			avg_new = uere_pkg::Q_MAX;
		end else begin
			avg_new = sum[QB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			width_q     <= q_width;
			trig_hold_q <= q_op.trig;
		end
		prod_s1 <= PW'(width_q) * PW'(cfg.scale);
		d_s2    <= d_sat;
		prod_s3 <= diff * $signed({1'b0, alpha_eff});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			avg_q       <= uere_pkg::EMA_RST;
			dist_q      <= '0;
			out_valid_q <= 1'b0;
			trig_q      <= 1'b0;
			done_q      <= 1'b0;
			tout_q      <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (pop && (q_op.kind == uere_pkg::KIND_MEAS)) begin
					st_q <= ST_MUL;
				end
				ST_MUL:  st_q <= ST_DIF;
				ST_DIF:  st_q <= ST_MAC;
				ST_MAC:  st_q <= ST_UPD;
				ST_UPD:  if (out_free) begin
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase

			if (ema_load) begin
				avg_q <= ema_value;
			end else if (load_meas) begin
				avg_q <= avg_new;
			end

			if (load_meas) begin
				dist_q      <= d_s2;
				out_valid_q <= 1'b1;
				trig_q      <= trig_hold_q;
				done_q      <= 1'b1;
				tout_q      <= 1'b0;
			end else if (load_plain) begin
				out_valid_q <= 1'b1;
				trig_q      <= q_op.trig;
				done_q      <= 1'b0;
				tout_q      <= (q_op.kind == uere_pkg::KIND_TOUT);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign trigger_level = trig_q;
	assign measure_done  = done_q;
	assign timed_out     = tout_q;
	assign distance_q8   = dist_q;
	assign smoothed_q8   = avg_q;

`ifndef SYNTHESIS
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(done_q && tout_q))
		else $error("done and timeout flags both set");
	a_mul_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MUL) |=> (st_q == ST_DIF))
		else $error("width multiply step did not advance");
	a_avg_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!ema_load && !load_meas) |=> $stable(avg_q))
		else $error("average changed without update or load");
`endif

endmodule

// ===== rtl/ultrasonic_echo_ranger_ema_unit.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_ema_unit
// Echo ranger: trigger timing, echo width measurement, distance scaling and
// exponential moving average, one result word per echo word.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------
//   input   | in_valid / in_stall   | echo_level
//   output  | out_valid / out_stall | trigger_level measure_done timed_out
//           |                       | distance_q8 smoothed_q8
//   config  | cfg_we                | cfg_index cfg_data
//
// Front takes one word a cycle while the two-entry queue has room.
// Back loads a word with no finished echo straight into its output; a finished
// echo runs width multiply, scale and saturate, alpha multiply, average update.
// Reset clears counters and flags, loads register defaults and the average.
// A stalled output holds its word; the queue then fills and raises in_stall.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_ema_unit #(
	parameter int COUNT_BITS  = uere_pkg::COUNT_BITS,
	parameter int QUEUE_DEPTH = uere_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [uere_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [uere_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            echo_level,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            trigger_level,
	output logic                            measure_done,
	output logic                            timed_out,
	output logic [uere_pkg::Q_BITS-1:0]     distance_q8,
	output logic [uere_pkg::Q_BITS-1:0]     smoothed_q8
);

	localparam int OPW = $bits(uere_pkg::op_t);
	localparam int EW  = OPW + COUNT_BITS;

	uere_pkg::cfg_t        cfg_q;
	logic                  ema_load;
	logic                  q_full, q_empty, push, pop;
	uere_pkg::op_t         push_op, q_op;
	logic [COUNT_BITS-1:0] push_width, q_width;
	logic [EW-1:0]         q_rdata;

	assign ema_load = cfg_we && (cfg_index == uere_pkg::REG_EMA_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout    <= uere_pkg::TIMEOUT_RST;
			cfg_q.alpha      <= uere_pkg::ALPHA_RST;
			cfg_q.scale      <= uere_pkg::SCALE_RST;
			cfg_q.period     <= uere_pkg::PERIOD_RST;
			cfg_q.trig_width <= uere_pkg::TRIG_W_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				uere_pkg::REG_TIMEOUT: cfg_q.timeout <= cfg_data[uere_pkg::TIMEOUT_W-1:0];
				uere_pkg::REG_ALPHA:   cfg_q.alpha   <= cfg_data[uere_pkg::ALPHA_W-1:0];
				uere_pkg::REG_SCALE:   cfg_q.scale   <= cfg_data[uere_pkg::SCALE_BITS-1:0];
				uere_pkg::REG_PERIOD:  cfg_q.period  <= cfg_data[uere_pkg::PERIOD_BITS-1:0];
				uere_pkg::REG_TRIG_W:  cfg_q.trig_width <= cfg_data[uere_pkg::TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	uere_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.echo_level (echo_level),
		.q_full     (q_full),
		.push       (push),
		.push_op    (push_op),
		.push_width (push_width)
	);

	uere_queue #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_op, push_width}),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign q_op    = q_rdata[EW-1:COUNT_BITS];
	assign q_width = q_rdata[COUNT_BITS-1:0];

	uere_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.ema_load      (ema_load),
		.ema_value     (cfg_data[uere_pkg::Q_BITS-1:0]),
		.q_empty       (q_empty),
		.q_op          (q_op),
		.q_width       (q_width),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.trigger_level (trigger_level),
		.measure_done  (measure_done),
		.timed_out     (timed_out),
		.distance_q8   (distance_q8),
		.smoothed_q8   (smoothed_q8)
	);

endmodule

// ===== tb/ultrasonic_echo_ranger_ema_unit_tb.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_ema_unit_tb
// Self-checking bench for the echo ranger. Echo words go in and result words
// come out, one for one. A predictor class tracks trigger timing, echo width,
// distance scaling and the moving average for every word it accepts. Each
// result word is compared field by field with the oldest prediction. The run
// covers directed extremes and random pulse trains under several sender idle
// and receiver stall mixes.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_ema_unit_tb;
	import uere_pkg::*;

	typedef struct packed {
		bit              trig;
		bit              done;
		bit              tout;
		bit [Q_BITS-1:0] distance;
		bit [Q_BITS-1:0] avg;
	} tick_t;

	class range_predictor;
		bit [TIMEOUT_W-1:0]   timeout;
		bit [ALPHA_W-1:0]     alpha;
		bit [SCALE_BITS-1:0]  scale;
		bit [PERIOD_BITS-1:0] period;
		bit [TRIG_W-1:0]      trig_width;
		bit                   prev_echo;
		bit                   measuring;
		bit [COUNT_BITS-1:0]  width_cnt;
		bit [PERIOD_BITS-1:0] period_cnt;
		bit [Q_BITS-1:0]      last_dist;
		bit [Q_BITS-1:0]      average;
		tick_t                expected_ticks[$];
		int                   errors;
		int                   words;
		int                   measured;
		int                   timeouts;

		function new();
			timeout    = TIMEOUT_RST;
			alpha      = ALPHA_RST;
			scale      = SCALE_RST;
			period     = PERIOD_RST;
			trig_width = TRIG_W_RST;
			average    = EMA_RST;
			prev_echo  = 1'b0;
			measuring  = 1'b0;
			width_cnt  = '0;
			period_cnt = '0;
			last_dist  = '0;
			errors     = 0;
			words      = 0;
			measured   = 0;
			timeouts   = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_TIMEOUT: timeout = data[TIMEOUT_W-1:0];
				REG_ALPHA: alpha = data[ALPHA_W-1:0];
				REG_SCALE: scale = data[SCALE_BITS-1:0];
				REG_PERIOD: period = data[PERIOD_BITS-1:0];
				REG_TRIG_W: trig_width = data[TRIG_W-1:0];
				REG_EMA_START: average = data[Q_BITS-1:0];
				default: ;
			endcase
		endfunction

		function void note_echo(bit echo);
			tick_t              t;
			bit [PERIOD_BITS:0] nxt;
			longint             d;
			longint             a;
			longint             sum;
			t = '0;
			words++;
			t.trig = period_cnt < trig_width;
			nxt = period_cnt + 1'b1;
			period_cnt = (nxt >= period) ? '0 : nxt[PERIOD_BITS-1:0];
			if (echo && !prev_echo) begin
				measuring = 1'b1;
				width_cnt = 1;
			end else if (echo && measuring) begin
				if (width_cnt != '1)
					width_cnt++;
			end else if (!echo && prev_echo && measuring) begin
				measuring = 1'b0;
				if (width_cnt > timeout) begin
					t.tout = 1'b1;
					timeouts++;
				end else begin
					d = (longint'(width_cnt) * longint'(scale)) >> (SCALE_BITS - FRAC_BITS);
					if (d > longint'(Q_MAX))
						d = longint'(Q_MAX);
					last_dist = d[Q_BITS-1:0];
					a = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
					sum = longint'(average) + (((d - longint'(average)) * a) >>> ALPHA_BITS);
					if (sum < 0)
						sum = 0;
					if (sum > longint'(Q_MAX))
						sum = longint'(Q_MAX);
					average = sum[Q_BITS-1:0];
					t.done = 1'b1;
					measured++;
				end
			end
			prev_echo = echo;
			t.distance = last_dist;
			t.avg = average;
			expected_ticks.push_back(t);
		endfunction

		function void check_field(string name, logic [Q_BITS-1:0] want, logic [Q_BITS-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_tick(logic trig, logic done, logic tout,
				logic [Q_BITS-1:0] distance, logic [Q_BITS-1:0] avg);
			tick_t t;
			if (expected_ticks.size() == 0) begin
				$error("result word with no echo word pending");
				errors++;
				return;
			end
			t = expected_ticks.pop_front();
			check_field("trigger_level", t.trig, trig);
			check_field("measure_done", t.done, done);
			check_field("timed_out", t.tout, tout);
			check_field("distance_q8", t.distance, distance);
			check_field("smoothed_q8", t.avg, avg);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_TIMEOUT;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   echo_level = 1'b0;
	logic                   out_stall = 1'b0;
	logic                   in_stall;
	logic                   out_valid;
	logic                   trigger_level;
	logic                   measure_done;
	logic                   timed_out;
	logic [Q_BITS-1:0]      distance_q8;
	logic [Q_BITS-1:0]      smoothed_q8;

	int             send_idle_pct = 0;
	int             stall_pct = 0;
	int             configs = 0;
	range_predictor ranger = new();

	ultrasonic_echo_ranger_ema_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.echo_level    (echo_level),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.trigger_level (trigger_level),
		.measure_done  (measure_done),
		.timed_out     (timed_out),
		.distance_q8   (distance_q8),
		.smoothed_q8   (smoothed_q8)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			ranger.note_echo(echo_level);
		if (arst_n && out_valid && !out_stall)
			ranger.check_tick(trigger_level, measure_done, timed_out, distance_q8, smoothed_q8);
	end

	// all six registers, one per cycle; bits above each register's width are junk
	task automatic configure(int unsigned tmo, int unsigned alpha, int unsigned scale,
			int unsigned period, int unsigned trig, int unsigned ema);
		int unsigned           vals[6];
		logic [CFG_DATA_W-1:0] mask;
		logic [CFG_DATA_W-1:0] data;
		vals = '{tmo, alpha, scale, period, trig, ema};
		for (int i = 0; i < 6; i++) begin
			case (CFG_INDEX_W'(i))
				REG_TIMEOUT: mask = 19'h0FFFF;
				REG_ALPHA: mask = 19'h001FF;
				REG_SCALE: mask = 19'h0FFFF;
				REG_PERIOD: mask = 19'h1FFFF;
				REG_TRIG_W: mask = 19'h000FF;
				default: mask = 19'h7FFFF;
			endcase
			data = (vals[i][CFG_DATA_W-1:0] & mask) | (CFG_DATA_W'($urandom) & ~mask);
			cfg_we <= 1'b1;
			cfg_index <= CFG_INDEX_W'(i);
			cfg_data <= data;
			@(posedge clk);
			ranger.write_reg(CFG_INDEX_W'(i), data);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		configs++;
	endtask

	task automatic send_echo(bit level);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		echo_level <= level;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_pulse(int unsigned width, int unsigned gap);
		repeat (width) send_echo(1'b1);
		repeat (gap) send_echo(1'b0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (ranger.expected_ticks.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int unsigned sent;
		int unsigned tmo;
		int unsigned w;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults
		send_echo(1'b0);
		send_pulse(1, 1);
		send_pulse(2, 1);
		drain();
		// min timeout, alpha above one, max scale, period 0, trigger always low
		configure(1, 511, 65535, 0, 0, 0);
		send_pulse(1, 1);
		send_pulse(2, 1);
		drain();
		// max timeout, alpha zero, period 1, trigger always high, max start
		configure(65535, 0, SCALE_RST, 1, 255, 524287);
		send_pulse(3, 1);
		drain();
		// scale zero with the smallest nonzero alpha pulls the average down
		configure(TIMEOUT_RST, 1, 0, 5, 3, 1000);
		send_pulse(1, 1);
		send_pulse(4, 2);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			tmo = ($urandom_range(3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 40);
			configure(tmo, $urandom_range(0, 511),
				($urandom_range(1) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2000),
				($urandom_range(3) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 200),
				$urandom_range(0, 255), $urandom_range(0, 524287));
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 49; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 49; end
				default: begin send_idle_pct = 23; stall_pct = 23; end
			endcase
			sent = 0;
			while (sent < 110) begin
				if ($urandom_range(9) == 0) begin
					send_echo($urandom_range(1));
					sent++;
				end else begin
					if ($urandom_range(4) == 0)
						w = $urandom_range(1, 300);
					else
						w = $urandom_range(1, (tmo < 40) ? tmo + 2 : 60);
					send_pulse(w, $urandom_range(1, 6));
					sent += w;
				end
			end
			drain();
		end

		$display("Ran %0d echo words under %0d register settings and four idle/stall mixes.",
			ranger.words, configs);
		$display("Echoes measured: %0d, echoes over the timeout: %0d.",
			ranger.measured, ranger.timeouts);
		if (ranger.errors == 0)
			$display("PASS ultrasonic_echo_ranger_ema_unit");
		else
			$display("FAIL ultrasonic_echo_ranger_ema_unit");
		$finish;
	end

	initial begin
		#8000000;
		$display("FAIL ultrasonic_echo_ranger_ema_unit");
		$finish;
	end

endmodule
